// ===== hdl/lcdseq_pkg.sv =====
package lcdseq_pkg;

    // default parameter values
    localparam int LCDSEQ_MAX_SHIFT     = 32;
    localparam int LCDSEQ_SHORT_WAIT_US = 40;

    // request codes
    localparam logic [2:0] FUNC_INIT  = 3'd0;
    localparam logic [2:0] FUNC_CMD   = 3'd1;
    localparam logic [2:0] FUNC_DATA  = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_SHIFT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FUNCTION_SET = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY_MODE   = 2'd2;

    // lcd command bytes and nibbles
    localparam logic [7:0] CMD_SHIFT_RIGHT = 8'b0001_1100;
    localparam logic [7:0] CMD_SHIFT_LEFT  = 8'b0001_1000;
    localparam logic [3:0] NIB_WAKE        = 4'b0011;
    localparam logic [3:0] NIB_FOUR_BIT    = 4'b0010;
    localparam logic [7:0] CMD_CLEAR       = 8'b0000_0001;
    localparam logic [7:0] RST_FUNCTION_SET = 8'b0010_1000;
    localparam logic [7:0] RST_DISPLAY_CTRL = 8'b0000_1100;
    localparam logic [7:0] RST_ENTRY_MODE   = 8'b0000_0110;

    // timing in microseconds
    localparam logic [15:0] INIT_WAIT_US   = 16'd50000;
    localparam logic [12:0] WAKE_WAIT1_US  = 13'd5000;
    localparam logic [12:0] WAKE_WAIT2_US  = 13'd150;
    localparam int          CLEAR_EXTRA_US = 2000;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic at_last;
    } t_ctrl_sts;

endpackage

// ===== hdl/lcdseq_ctrl.sv =====
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    input  logic      i_m_tready,
    input  logic      i_out_valid,
    input  t_ctrl_sts i_sts,
    output logic      o_s_tready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_cmd.step = (r_state == ST_RUN) && (!i_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && !i_sts.empty) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (o_cmd.step && i_sts.at_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a request with no strobes never leaves idle
    a_empty_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_sts.empty) |=> (r_state == ST_IDLE))
        else $error("empty request left idle");

    // no step may overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (!i_out_valid || i_m_tready))
        else $error("strobe stepped over a pending result");

    // the final strobe returns control to idle
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.at_last) |=> o_s_tready)
        else $error("run did not end after last strobe");

endmodule

// ===== hdl/lcdseq_dp.sv =====
module lcdseq_dp
    import lcdseq_pkg::*;
#(
    parameter int MAX_SHIFT     = LCDSEQ_MAX_SHIFT,
    parameter int SHORT_WAIT_US = LCDSEQ_SHORT_WAIT_US
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  t_ctrl_cmd   i_cmd,
    output t_ctrl_sts   o_sts,
    output logic        o_out_valid,
    output logic [39:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int MAX_STROBES = (2 * MAX_SHIFT > 12) ? 2 * MAX_SHIFT : 12;
    localparam int CNT_W       = $clog2(MAX_STROBES);

    localparam logic [12:0] SHORT_US     = 13'(SHORT_WAIT_US);
    localparam logic [12:0] CLEAR_US     = 13'(CLEAR_EXTRA_US + SHORT_WAIT_US);
    localparam logic [6:0]  MAX_SHIFT_7  = 7'(MAX_SHIFT);
    localparam logic [CNT_W-1:0] LAST_INIT = CNT_W'(11);
    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(1);

    // configuration
    logic [7:0] r_fset;
    logic [7:0] r_dctl;
    logic [7:0] r_emode;

    // request in progress
    logic [2:0]       r_func;
    logic [7:0]       r_byte;
    logic             r_right;
    logic [CNT_W-1:0] r_last_idx;
    logic [CNT_W-1:0] r_idx;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_out_nib;
    logic        r_out_rs;
    logic [15:0] r_out_before;
    logic [12:0] r_out_after;
    logic        r_out_last;

    // request decode
    logic signed [6:0] s_amt;
    logic [6:0]        s_mag;
    logic [6:0]        s_sat;
    logic [7:0]        s_shift_last;
    logic [CNT_W-1:0]  s_last_idx;
    logic              s_empty;

    // current strobe
    logic [3:0]  s_nib;
    logic        s_rs;
    logic [15:0] s_before;
    logic [12:0] s_after;
    logic [7:0]  s_shift_cmd;

    assign s_amt        = i_s_tdata[14:8];
    assign s_mag        = s_amt[6] ? 7'(-s_amt) : 7'(s_amt);
    assign s_sat        = (s_mag > MAX_SHIFT_7) ? MAX_SHIFT_7 : s_mag;
    assign s_shift_last = {s_sat, 1'b0} - 8'd1;

    always_comb begin
        s_last_idx = '0;
        s_empty    = 1'b0;
        case (i_s_tuser)
            FUNC_INIT:  s_last_idx = LAST_INIT;
            FUNC_CMD:   s_last_idx = LAST_BYTE;
            FUNC_DATA:  s_last_idx = LAST_BYTE;
            FUNC_CLEAR: s_last_idx = LAST_BYTE;
            FUNC_SHIFT: begin
                s_last_idx = s_shift_last[CNT_W-1:0];
                s_empty    = (s_sat == 7'd0);
            end
            default:    s_empty = 1'b1;
        endcase
    end

    assign o_sts.empty   = s_empty;
    assign o_sts.at_last = (r_idx == r_last_idx);

    assign s_shift_cmd = r_right ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;

    always_comb begin
        s_nib    = '0;
        s_rs     = 1'b0;
        s_before = '0;
        s_after  = SHORT_US;
        case (r_func)
            FUNC_INIT: begin
                case (r_idx[3:0])
                    4'd0: begin
                        s_nib    = NIB_WAKE;
                        s_before = INIT_WAIT_US;
                        s_after  = WAKE_WAIT1_US;
                    end
                    4'd1: begin
                        s_nib   = NIB_WAKE;
                        s_after = WAKE_WAIT2_US;
                    end
                    4'd2:  s_nib = NIB_WAKE;
                    4'd3:  s_nib = NIB_FOUR_BIT;
                    4'd4:  s_nib = r_fset[7:4];
                    4'd5:  s_nib = r_fset[3:0];
                    4'd6:  s_nib = r_dctl[7:4];
                    4'd7:  s_nib = r_dctl[3:0];
                    4'd8:  s_nib = r_emode[7:4];
                    4'd9:  s_nib = r_emode[3:0];
                    4'd10: s_nib = CMD_CLEAR[7:4];
                    4'd11: begin
                        s_nib   = CMD_CLEAR[3:0];
                        s_after = CLEAR_US;
                    end
                    default: s_nib = '0;
                endcase
            end
            FUNC_CMD: s_nib = r_idx[0] ? r_byte[3:0] : r_byte[7:4];
            FUNC_DATA: begin
                s_nib = r_idx[0] ? r_byte[3:0] : r_byte[7:4];
                s_rs  = 1'b1;
            end
            FUNC_CLEAR: begin
                s_nib   = r_idx[0] ? CMD_CLEAR[3:0] : CMD_CLEAR[7:4];
                s_after = r_idx[0] ? CLEAR_US : SHORT_US;
            end
            FUNC_SHIFT: s_nib = r_idx[0] ? s_shift_cmd[3:0] : s_shift_cmd[7:4];
            default:    s_nib = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fset  <= RST_FUNCTION_SET;
            r_dctl  <= RST_DISPLAY_CTRL;
            r_emode <= RST_ENTRY_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FUNCTION_SET: r_fset  <= i_cfg_data;
                CFG_DISPLAY_CTRL: r_dctl  <= i_cfg_data;
                CFG_ENTRY_MODE:   r_emode <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_s_tuser;
            r_byte     <= i_s_tdata[7:0];
            r_right    <= !s_amt[6];
            r_last_idx <= s_last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_nib    <= s_nib;
            r_out_rs     <= s_rs;
            r_out_before <= s_before;
            r_out_after  <= s_after;
            r_out_last   <= o_sts.at_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_after, r_out_before, r_out_nib};
    assign o_m_tuser   = r_out_rs;
    assign o_m_tlast   = r_out_last;

    // the step counter never runs past the final strobe
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_idx <= r_last_idx))
        else $error("strobe index beyond last");

    // a step always leaves a result in the output register
    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_out_valid)
        else $error("step did not fill output");

    // a new request always starts at its first strobe
    a_load_resets_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_idx == '0))
        else $error("request did not start at first strobe");

endmodule

// ===== hdl/char_lcd_nibble_sequencer_core.sv =====
// Character LCD 4-bit sequencer. Each request item on the slave stream (init, command byte,
// data byte, clear, shift) is turned into a run of enable-strobe items on the master
// stream, each carrying the bus nibble, the register-select level and the waits before
// and after the strobe, with tlast on the final strobe. A request takes 12 strobes for
// init, 2 for a byte or a clear, 2*|n| for a shift (n saturated to MAX_SHIFT) and none
// for a zero shift or an unknown code. One strobe leaves per clock while the master side
// takes it, paced by a single step counter that walks the strobe table; s_tready is high
// only between runs, so no new request is taken until the current one's last strobe has
// entered the output register. Requests without strobes are absorbed in their accept cycle.
// The set-up commands sent during init come from the configuration port, which is always
// ready and must be written while no run is active.
module char_lcd_nibble_sequencer_core
    import lcdseq_pkg::*;
#(
    parameter int MAX_SHIFT     = LCDSEQ_MAX_SHIFT,
    parameter int SHORT_WAIT_US = LCDSEQ_SHORT_WAIT_US
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] byte_value, [14:8] shift_amount, [15] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] func

    // strobe stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [3:0] nibble, [19:4] wait_before_us,
                                     // [32:20] wait_after_us, [39:33] zero
    output logic        o_m_tuser,   // [0] reg_select
    output logic        o_m_tlast,   // last strobe of the request

    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_ctrl_cmd s_cmd;
    t_ctrl_sts s_sts;
    logic      s_out_valid;

    // registers accept a write on any cycle
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = s_out_valid;

    // sequencing: idle / run, steps the strobe counter
    lcdseq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_m_tready  (i_m_tready),
        .i_out_valid (s_out_valid),
        .i_sts       (s_sts),
        .o_s_tready  (o_s_tready),
        .o_cmd       (s_cmd)
    );

    // request capture, strobe table, config registers and output register
    lcdseq_dp #(
        .MAX_SHIFT     (MAX_SHIFT),
        .SHORT_WAIT_US (SHORT_WAIT_US)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_out_valid (s_out_valid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lcdseq_pkg::*;

    // one enable strobe as seen on the master stream
    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic [15:0] before_us;
        logic [12:0] after_us;
        logic        last;
    } strobe_t;

    // one row of the directed table; typed rows carry their strobes inline
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_val;
        logic [6:0] shift;
        logic       typed;
        logic [1:0] n_typed;
        strobe_t    s0;
        strobe_t    s1;
    } dir_row_t;

    localparam logic [12:0] SHORT_US = 13'(LCDSEQ_SHORT_WAIT_US);
    localparam logic [12:0] CLEAR_US = 13'(CLEAR_EXTRA_US + LCDSEQ_SHORT_WAIT_US);
    localparam logic [2:0]  FUNC_UNKNOWN_LO = 3'd5;
    localparam logic [2:0]  FUNC_UNKNOWN_HI = 3'd7;
    localparam int          IDLE_PCT       = 23;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          N_DIR          = 22;
    localparam strobe_t     NONE           = '0;

    // shorthand for the strobe rows typed into the table
    localparam strobe_t CMD_F_HI = '{4'hF, 1'b0, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t CMD_F_LO = '{4'hF, 1'b0, 16'd0, SHORT_US, 1'b1};
    localparam strobe_t CMD_0_HI = '{4'h0, 1'b0, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t CMD_0_LO = '{4'h0, 1'b0, 16'd0, SHORT_US, 1'b1};
    localparam strobe_t DAT_F_HI = '{4'hF, 1'b1, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t DAT_F_LO = '{4'hF, 1'b1, 16'd0, SHORT_US, 1'b1};
    localparam strobe_t DAT_0_HI = '{4'h0, 1'b1, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t DAT_0_LO = '{4'h0, 1'b1, 16'd0, SHORT_US, 1'b1};
    localparam strobe_t CLR_HI   = '{CMD_CLEAR[7:4], 1'b0, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t CLR_LO   = '{CMD_CLEAR[3:0], 1'b0, 16'd0, CLEAR_US, 1'b1};
    localparam strobe_t SHR_HI   = '{CMD_SHIFT_RIGHT[7:4], 1'b0, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t SHR_LO   = '{CMD_SHIFT_RIGHT[3:0], 1'b0, 16'd0, SHORT_US, 1'b1};
    localparam strobe_t SHL_HI   = '{CMD_SHIFT_LEFT[7:4], 1'b0, 16'd0, SHORT_US, 1'b0};
    localparam strobe_t SHL_LO   = '{CMD_SHIFT_LEFT[3:0], 1'b0, 16'd0, SHORT_US, 1'b1};

    // directed requests: extremes of every field, every code, saturation,
    // zero shift, unknown codes and ignored fields
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{FUNC_INIT,       8'h00, 7'h00, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_CMD,        8'h00, 7'h00, 1'b1, 2'd2, CMD_0_HI, CMD_0_LO},
        '{FUNC_CMD,        8'hFF, 7'h00, 1'b1, 2'd2, CMD_F_HI, CMD_F_LO},
        '{FUNC_DATA,       8'h00, 7'h00, 1'b1, 2'd2, DAT_0_HI, DAT_0_LO},
        '{FUNC_DATA,       8'hFF, 7'h7F, 1'b1, 2'd2, DAT_F_HI, DAT_F_LO},
        '{FUNC_DATA,       8'hA5, 7'h00, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_CLEAR,      8'h00, 7'h00, 1'b1, 2'd2, CLR_HI,   CLR_LO},
        '{FUNC_UNKNOWN_LO, 8'h00, 7'h00, 1'b1, 2'd0, NONE,     NONE},
        '{FUNC_UNKNOWN_HI, 8'hFF, 7'h7F, 1'b1, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'hFF, 7'h00, 1'b1, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'h01, 1'b1, 2'd2, SHR_HI,   SHR_LO},
        '{FUNC_SHIFT,      8'h00, 7'h7F, 1'b1, 2'd2, SHL_HI,   SHL_LO},
        '{FUNC_SHIFT,      8'h00, 7'd32, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'h60, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'd33, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'h3F, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'h40, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_SHIFT,      8'h00, 7'h5F, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_CMD,        8'h3C, 7'h55, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_CLEAR,      8'hFF, 7'h7F, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_INIT,       8'hFF, 7'h7F, 1'b0, 2'd0, NONE,     NONE},
        '{FUNC_DATA,       8'h5A, 7'h2A, 1'b0, 2'd0, NONE,     NONE}
    };

    // dut input ports, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [15:0] i_s_tdata   = '0;
    logic [2:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        o_cfg_ready;

    // predictor copy of the set-up registers
    logic [7:0] setup_function_set = RST_FUNCTION_SET;
    logic [7:0] setup_display_ctrl = RST_DISPLAY_CTRL;
    logic [7:0] setup_entry_mode   = RST_ENTRY_MODE;

    // strobes still owed by the dut, oldest first
    strobe_t strobe_q[$];
    strobe_t got_strobe;
    strobe_t want_strobe;
    int      mismatch_cnt = 0;
    int      idle_pct     = IDLE_PCT;

    char_lcd_nibble_sequencer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // strobe predictor
    // ---------------------------------------------------------------
    function automatic void push_strobe(input logic [3:0] nib, input logic rs,
                                        input logic [15:0] before_us,
                                        input logic [12:0] after_us);
        strobe_q.push_back('{nib, rs, before_us, after_us, 1'b0});
    endfunction

    // a byte goes out high nibble first; only the low half has its own wait
    function automatic void push_byte(input logic [7:0] b, input logic rs,
                                      input logic [12:0] after_low);
        push_strobe(b[7:4], rs, 16'd0, SHORT_US);
        push_strobe(b[3:0], rs, 16'd0, after_low);
    endfunction

    // appends the strobes of one request and returns how many there were
    function automatic int predict_strobes(input logic [2:0] f, input logic [7:0] b,
                                           input logic [6:0] sh);
        int first;
        int amount;
        int n;
        first  = strobe_q.size();
        amount = sh[6] ? int'(sh) - 128 : int'(sh);
        case (f)
            FUNC_INIT: begin
                // wake-up nibbles with the long power-on waits, then the 4-bit switch
                push_strobe(NIB_WAKE, 1'b0, INIT_WAIT_US, WAKE_WAIT1_US);
                push_strobe(NIB_WAKE, 1'b0, 16'd0, WAKE_WAIT2_US);
                push_strobe(NIB_WAKE, 1'b0, 16'd0, SHORT_US);
                push_strobe(NIB_FOUR_BIT, 1'b0, 16'd0, SHORT_US);
                push_byte(setup_function_set, 1'b0, SHORT_US);
                push_byte(setup_display_ctrl, 1'b0, SHORT_US);
                push_byte(setup_entry_mode, 1'b0, SHORT_US);
                push_byte(CMD_CLEAR, 1'b0, CLEAR_US);
            end
            FUNC_CMD:   push_byte(b, 1'b0, SHORT_US);
            FUNC_DATA:  push_byte(b, 1'b1, SHORT_US);
            FUNC_CLEAR: push_byte(CMD_CLEAR, 1'b0, CLEAR_US);
            FUNC_SHIFT: begin
                // saturate, then one shift command per step; zero shifts left by nothing
                if (amount > LCDSEQ_MAX_SHIFT) amount = LCDSEQ_MAX_SHIFT;
                if (amount < -LCDSEQ_MAX_SHIFT) amount = -LCDSEQ_MAX_SHIFT;
                n = (amount < 0) ? -amount : amount;
                for (int i = 0; i < n; i++)
                    push_byte((amount > 0) ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT, 1'b0, SHORT_US);
            end
            default: ;  // unknown codes are swallowed
        endcase
        if (strobe_q.size() > first) strobe_q[strobe_q.size() - 1].last = 1'b1;
        return strobe_q.size() - first;
    endfunction

    // ---------------------------------------------------------------
    // request and config drivers
    // ---------------------------------------------------------------
    // valid stays high until the accept edge; idle cycles only come before an offer
    task automatic offer_request(input logic [2:0] f, input logic [7:0] b,
                                 input logic [6:0] sh);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {1'b0, sh, b};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic write_setup_reg(input logic [1:0] idx, input logic [7:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FUNCTION_SET: setup_function_set = val;
            CFG_DISPLAY_CTRL: setup_display_ctrl = val;
            CFG_ENTRY_MODE:   setup_entry_mode   = val;
            default: ;
        endcase
    endtask

    // stop offering, let every owed strobe arrive, then give swallowed items time
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (strobe_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [7:0] fs, input logic [7:0] dc,
                              input logic [7:0] em);
        wait_quiet();
        write_setup_reg(CFG_FUNCTION_SET, fs);
        write_setup_reg(CFG_DISPLAY_CTRL, dc);
        write_setup_reg(CFG_ENTRY_MODE, em);
        i_cfg_valid <= 1'b0;
    endtask

    // random requests, opening with an init so the current set-up gets used;
    // only requests that produce strobes count toward the target
    task automatic run_random(input int target);
        int produced;
        int r;
        logic [2:0] f;
        logic [7:0] b;
        logic [6:0] sh;
        produced = 0;
        f  = FUNC_INIT;
        b  = 8'($urandom);
        sh = 7'($urandom);
        while (produced < target) begin
            offer_request(f, b, sh);
            if (predict_strobes(f, b, sh) > 0) produced++;
            r  = $urandom_range(0, 99);
            b  = 8'($urandom);
            sh = 7'($urandom);
            if (r < 5) f = FUNC_INIT;
            else if (r < 30) f = FUNC_CMD;
            else if (r < 55) f = FUNC_DATA;
            else if (r < 63) f = FUNC_CLEAR;
            else if (r < 92) begin
                // mostly short shifts, the rest over the whole signed range
                f = FUNC_SHIFT;
                if ($urandom_range(0, 3) != 0) begin
                    sh = 7'($urandom_range(1, 4));
                    if ($urandom_range(0, 1) != 0) sh = -sh;
                end
            end else if (r < 96) begin
                f  = FUNC_SHIFT;
                sh = 7'd0;
            end else begin
                f = 3'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // strobe side: random back-pressure and the checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_strobe = {o_m_tdata[3:0], o_m_tuser, o_m_tdata[19:4], o_m_tdata[32:20],
                          o_m_tlast};
            if (strobe_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected strobe: nib=%h rs=%b before=%0d after=%0d last=%b",
                             got_strobe.nibble, got_strobe.rs, got_strobe.before_us,
                             got_strobe.after_us, got_strobe.last);
                mismatch_cnt++;
            end else begin
                want_strobe = strobe_q.pop_front();
                if (got_strobe !== want_strobe) begin
                    if (mismatch_cnt < 10) begin
                        $display("strobe mismatch at %0t", $realtime);
                        $display("  expected nib=%h rs=%b before=%0d after=%0d last=%b",
                                 want_strobe.nibble, want_strobe.rs, want_strobe.before_us,
                                 want_strobe.after_us, want_strobe.last);
                        $display("  actual   nib=%h rs=%b before=%0d after=%0d last=%b",
                                 got_strobe.nibble, got_strobe.rs, got_strobe.before_us,
                                 got_strobe.after_us, got_strobe.last);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table against the reset set-up
        for (int k = 0; k < N_DIR; k++) begin
            offer_request(DIR_TAB[k].func, DIR_TAB[k].byte_val, DIR_TAB[k].shift);
            if (DIR_TAB[k].typed) begin
                if (DIR_TAB[k].n_typed > 0) strobe_q.push_back(DIR_TAB[k].s0);
                if (DIR_TAB[k].n_typed > 1) strobe_q.push_back(DIR_TAB[k].s1);
            end else begin
                void'(predict_strobes(DIR_TAB[k].func, DIR_TAB[k].byte_val,
                                      DIR_TAB[k].shift));
            end
        end

        run_random(40);

        // all-zero set-up
        load_setup(8'h00, 8'h00, 8'h00);
        run_random(35);

        // all-ones set-up, run without any idling on either side
        load_setup(8'hFF, 8'hFF, 8'hFF);
        idle_pct = 0;
        run_random(35);
        idle_pct = IDLE_PCT;

        // random set-up
        load_setup(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(55);

        wait_quiet();
        if (mismatch_cnt == 0 && strobe_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== char_lcd_nibble_sequencer_core.f =====
hdl/lcdseq_pkg.sv
hdl/lcdseq_ctrl.sv
hdl/lcdseq_dp.sv
hdl/char_lcd_nibble_sequencer_core.sv
tb/sv/tb_top.sv
